/* rtl/imuacf_pkg.sv */
// Package: types, constants and helpers for the IMU complementary filter.
`default_nettype none
package imuacf_pkg;

  localparam int CordicSteps = 20;
  localparam int CordicIdxW  = $clog2(CordicSteps);
  localparam int SqrtIters   = 32;
  localparam int SqrtIdxW    = $clog2(SqrtIters);
  localparam int AddrW       = 6;
  localparam int DataW       = 64;

  localparam logic signed [32:0] WAccNew = 33'sd13107;
  localparam logic signed [32:0] WAccOld = 33'sd52429;
  localparam logic signed [32:0] WLo     = 33'sd6554;
  localparam logic signed [32:0] WHi     = 33'sd58982;

  typedef enum logic [2:0] {
    REG_ACC_OFF_X = 3'd0,
    REG_ACC_OFF_Y = 3'd1,
    REG_ACC_OFF_Z = 3'd2,
    REG_GYR_OFF_X = 3'd3,
    REG_GYR_OFF_Y = 3'd4,
    REG_GYR_OFF_Z = 3'd5,
    REG_TRIMS     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] accel_raw_x;
    logic signed [15:0] accel_raw_y;
    logic signed [15:0] accel_raw_z;
    logic signed [15:0] gyro_raw_x;
    logic signed [15:0] gyro_raw_y;
    logic signed [15:0] gyro_raw_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] yaw_angle;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] roll_angle;
    logic signed [31:0] yaw_rate;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] roll_rate;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [63:0]        sq_sum;
    logic signed [31:0] opp;
  } tilt_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] angle;
  } tilt_rsp_t;

  function automatic logic signed [31:0] atan_deg(input logic [CordicIdxW-1:0] i);
    logic signed [31:0] v;
    case (i)
      0: v = 32'sd2949120;  1: v = 32'sd1740967;  2: v = 32'sd919879;
      3: v = 32'sd466945;   4: v = 32'sd234379;   5: v = 32'sd117304;
      6: v = 32'sd58666;    7: v = 32'sd29335;    8: v = 32'sd14668;
      9: v = 32'sd7334;     10: v = 32'sd3667;    11: v = 32'sd1833;
      12: v = 32'sd917;     13: v = 32'sd458;     14: v = 32'sd229;
      15: v = 32'sd115;     16: v = 32'sd57;      17: v = 32'sd29;
      18: v = 32'sd14;      19: v = 32'sd7;       20: v = 32'sd4;
      21: v = 32'sd2;       22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] round_sat(input logic signed [65:0] s);
    logic signed [65:0] r;
    r = (s + 66'sd32768) >>> 16;
    if (r > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (r < -66'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/imuacf_tilt.sv */
// Tilt unit: iterative square root followed by a CORDIC vectoring atan2.
`default_nettype none
module imuacf_tilt
  import imuacf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tilt_req_t req_i,
  output tilt_rsp_t      rsp_o
);

  typedef enum logic [1:0] {T_IDLE, T_SQRT, T_CORD} tstate_e;

  tstate_e                 state_q;
  logic [63:0]             v_q, r_q;
  logic [SqrtIdxW-1:0]     n_q;
  logic signed [31:0]      opp_q;
  logic signed [39:0]      x_q, y_q;
  logic signed [31:0]      z_q;
  logic [CordicIdxW-1:0]   i_q;
  logic                    done_q;
  logic signed [31:0]      angle_q;

  logic [63:0]        bit_w, trial, v_d, r_d;
  logic signed [39:0] xs, ys, x_d, y_d;
  logic signed [31:0] z_d;

  always_comb begin
    bit_w = 64'd1 << {n_q, 1'b0};
    trial = r_q + bit_w;
    if (v_q >= trial) begin
      v_d = v_q - trial;
      r_d = (r_q >> 1) + bit_w;
    end else begin
      v_d = v_q;
      r_d = r_q >> 1;
    end
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    if (y_q > 40'sd0) begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + atan_deg(i_q);
    end else begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - atan_deg(i_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      done_q  <= 1'b0;
      n_q     <= '0;
      i_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        T_IDLE: begin
          if (req_i.start) begin
            v_q     <= req_i.sq_sum;
            r_q     <= '0;
            opp_q   <= req_i.opp;
            n_q     <= SqrtIdxW'(SqrtIters - 1);
            state_q <= T_SQRT;
          end
        end
        T_SQRT: begin
          v_q <= v_d;
          r_q <= r_d;
          n_q <= n_q - 1'b1;
          if (n_q == '0) begin
            x_q <= $signed({6'd0, r_d[33:0]});
            y_q <= 40'(opp_q);
            z_q <= '0;
            i_q <= '0;
            if (opp_q == 32'sd0) begin
              angle_q <= '0;
              done_q  <= 1'b1;
              state_q <= T_IDLE;
            end else begin
              state_q <= T_CORD;
            end
          end
        end
        T_CORD: begin
          x_q <= x_d;
          y_q <= y_d;
          z_q <= z_d;
          i_q <= i_q + 1'b1;
          if (i_q == CordicIdxW'(CordicSteps - 1)) begin
            angle_q <= z_d;
            done_q  <= 1'b1;
            state_q <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = angle_q;

endmodule
`default_nettype wire

/* rtl/imu_attitude_complementary_filter_unit.sv */
// Top level: IMU attitude complementary filter with shared MAC and tilt unit.
// Usage:
//   Input channel in_valid_i/in_stall_o carries one request of six raw samples.
//   Output channel out_valid_o/out_stall_i returns yaw, pitch, roll angles and
//   rates in Q16.16 degrees. One request is in work at a time; in_stall_o stays
//   high from acceptance until the result is taken.
//   Steps: the accel filter (a multiply-accumulate round per axis), two tilt
//   evaluations (two squares, 32 square-root steps, then 20 CORDIC steps
//   unless the opposite term is zero), the rate filters (a round per axis)
//   and the pitch and roll blends, then the result. One request is handled at
//   a time on the one shared 33x33 multiplier and square-root/CORDIC unit.
//   The result holds on the output while out_stall_i is high; no new request
//   is taken until it is accepted.
//   Reset clears all filter state and configuration registers to zero.
//   Configuration registers sit on the APB port at byte address 8*index.
`default_nettype none
module imu_attitude_complementary_filter_unit
  import imuacf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC_N, S_ACC_O, S_ACC_W, S_SQ_A, S_SQ_B, S_TILT_GO, S_TILT_WAIT,
    S_RATE_N, S_RATE_O, S_RATE_W, S_BL_N, S_BL_O, S_BL_W, S_OUT
  } state_e;

  state_e             state_q;
  logic [1:0]         k_q;
  in_item_t           in_q;
  logic [15:0]        acc_off_q [3];
  logic [15:0]        gyr_off_q [3];
  logic [47:0]        trims_q;
  logic signed [31:0] facc_q [3];
  logic signed [31:0] rate_q [3];
  logic signed [31:0] yaw_q, pitch_q, roll_q;
  logic signed [31:0] tilt_q [2];
  logic signed [65:0] mac_q;

  logic signed [15:0] acc_c [3];
  logic signed [15:0] gyr_c [3];
  logic signed [15:0] g_rate, g_bl;
  logic signed [32:0] mul_a, mul_b, ang_ext;
  logic signed [65:0] prod, mac_d;
  logic               mac_en, mac_clr;
  logic signed [31:0] wb;
  tilt_req_t          treq;
  tilt_rsp_t          trsp;
  logic [2:0]         widx;

  assign acc_c[0] = in_q.accel_raw_x - acc_off_q[0];
  assign acc_c[1] = in_q.accel_raw_y - acc_off_q[1];
  assign acc_c[2] = in_q.accel_raw_z - acc_off_q[2];
  assign gyr_c[0] = in_q.gyro_raw_x - gyr_off_q[0];
  assign gyr_c[1] = in_q.gyro_raw_y - gyr_off_q[1];
  assign gyr_c[2] = in_q.gyro_raw_z - gyr_off_q[2];

  always_comb begin
    case (k_q)
      2'd0:    g_rate = gyr_c[0];
      2'd1:    g_rate = gyr_c[2];
      default: g_rate = gyr_c[1];
    endcase
    g_bl    = k_q[0] ? gyr_c[1] : gyr_c[2];
    ang_ext = 33'(k_q[0] ? roll_q : pitch_q) + 33'(g_bl) * 33'sd40;
    mul_a   = '0;
    mul_b   = '0;
    mac_en  = 1'b0;
    mac_clr = 1'b0;
    case (state_q)
      S_ACC_N: begin
        mul_a = $signed({acc_c[k_q][15], acc_c[k_q], 16'd0});
        mul_b = WAccNew; mac_en = 1'b1; mac_clr = 1'b1;
      end
      S_ACC_O: begin
        mul_a = 33'(facc_q[k_q]); mul_b = WAccOld; mac_en = 1'b1;
      end
      S_SQ_A: begin
        mul_a = 33'(facc_q[0]); mul_b = mul_a; mac_en = 1'b1; mac_clr = 1'b1;
      end
      S_SQ_B: begin
        mul_a = 33'(k_q[0] ? facc_q[1] : facc_q[2]); mul_b = mul_a; mac_en = 1'b1;
      end
      S_RATE_N: begin
        mul_a = 33'(g_rate) * 33'sd2000; mul_b = WLo; mac_en = 1'b1; mac_clr = 1'b1;
      end
      S_RATE_O: begin
        mul_a = 33'(rate_q[k_q]); mul_b = WHi; mac_en = 1'b1;
      end
      S_BL_N: begin
        mul_a = ang_ext; mul_b = WHi; mac_en = 1'b1; mac_clr = 1'b1;
      end
      S_BL_O: begin
        mul_a = 33'(tilt_q[k_q[0]]); mul_b = WLo; mac_en = 1'b1;
      end
      default: ;
    endcase
    prod  = mul_a * mul_b;
    mac_d = mac_clr ? prod : mac_q + prod;
  end

  assign wb = round_sat(mac_q);

  assign treq.start  = (state_q == S_TILT_GO);
  assign treq.sq_sum = mac_q[63:0];
  assign treq.opp    = k_q[0] ? facc_q[2] : facc_q[1];

  imuacf_tilt u_tilt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (treq),
    .rsp_o  (trsp)
  );

  assign widx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      for (int j = 0; j < 3; j++) begin
        acc_off_q[j] <= '0;
        gyr_off_q[j] <= '0;
        facc_q[j]    <= '0;
        rate_q[j]    <= '0;
      end
      trims_q <= '0;
      yaw_q   <= '0;
      pitch_q <= '0;
      roll_q  <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (cfg_idx_e'(widx))
          REG_ACC_OFF_X: acc_off_q[0] <= pwdata[15:0];
          REG_ACC_OFF_Y: acc_off_q[1] <= pwdata[15:0];
          REG_ACC_OFF_Z: acc_off_q[2] <= pwdata[15:0];
          REG_GYR_OFF_X: gyr_off_q[0] <= pwdata[15:0];
          REG_GYR_OFF_Y: gyr_off_q[1] <= pwdata[15:0];
          REG_GYR_OFF_Z: gyr_off_q[2] <= pwdata[15:0];
          REG_TRIMS:     trims_q      <= pwdata[47:0];
          default: ;
        endcase
      end
      if (mac_en) mac_q <= mac_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            in_q    <= in_data_i;
            k_q     <= '0;
            state_q <= S_ACC_N;
          end
        end
        S_ACC_N: state_q <= S_ACC_O;
        S_ACC_O: state_q <= S_ACC_W;
        S_ACC_W: begin
          facc_q[k_q] <= wb;
          if (k_q == 2'd2) begin
            k_q     <= '0;
            state_q <= S_SQ_A;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_ACC_N;
          end
        end
        S_SQ_A:    state_q <= S_SQ_B;
        S_SQ_B:    state_q <= S_TILT_GO;
        S_TILT_GO: state_q <= S_TILT_WAIT;
        S_TILT_WAIT: begin
          if (trsp.done) begin
            if (k_q[0]) begin
              tilt_q[1] <= -trsp.angle;
              k_q       <= '0;
              state_q   <= S_RATE_N;
            end else begin
              tilt_q[0] <= trsp.angle;
              k_q       <= 2'd1;
              state_q   <= S_SQ_A;
            end
          end
        end
        S_RATE_N: state_q <= S_RATE_O;
        S_RATE_O: state_q <= S_RATE_W;
        S_RATE_W: begin
          rate_q[k_q] <= wb;
          if (k_q == 2'd0) yaw_q <= yaw_q + 32'(gyr_c[0]) * 32'sd40;
          if (k_q == 2'd2) begin
            k_q     <= '0;
            state_q <= S_BL_N;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_RATE_N;
          end
        end
        S_BL_N: state_q <= S_BL_O;
        S_BL_O: state_q <= S_BL_W;
        S_BL_W: begin
          if (k_q[0]) begin
            roll_q  <= wb;
            state_q <= S_OUT;
          end else begin
            pitch_q <= wb;
            k_q     <= 2'd1;
            state_q <= S_BL_N;
          end
        end
        S_OUT: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx_e'(widx))
      REG_ACC_OFF_X: prdata = DataW'(acc_off_q[0]);
      REG_ACC_OFF_Y: prdata = DataW'(acc_off_q[1]);
      REG_ACC_OFF_Z: prdata = DataW'(acc_off_q[2]);
      REG_GYR_OFF_X: prdata = DataW'(gyr_off_q[0]);
      REG_GYR_OFF_Y: prdata = DataW'(gyr_off_q[1]);
      REG_GYR_OFF_Z: prdata = DataW'(gyr_off_q[2]);
      REG_TRIMS:     prdata = DataW'(trims_q);
      default:       prdata = '0;
    endcase
  end

  assign pready      = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  assign out_data_o.yaw_angle   = yaw_q   - {{6{trims_q[15]}}, trims_q[15:0], 10'd0};
  assign out_data_o.pitch_angle = pitch_q - {{6{trims_q[31]}}, trims_q[31:16], 10'd0};
  assign out_data_o.roll_angle  = roll_q  - {{6{trims_q[47]}}, trims_q[47:32], 10'd0};
  assign out_data_o.yaw_rate    = rate_q[0];
  assign out_data_o.pitch_rate  = rate_q[1];
  assign out_data_o.roll_rate   = rate_q[2];

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("request taken while result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_tilt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trsp.done |-> state_q == S_TILT_WAIT) else $error("tilt result unexpected");

endmodule
`default_nettype wire
